### hw/rtl/tcse_pkg.sv
// ----------------------------------------------------------------------------
// tcse_pkg
// shared constants and types of the text console scroll engine
// ----------------------------------------------------------------------------
package tcse_pkg;

  // character store geometry
  localparam int STORE_CELLS = 16384;
  localparam int AW          = $clog2(STORE_CELLS);
  localparam int QW          = $clog2(STORE_CELLS + 1);
  localparam int LN_W        = $clog2(STORE_CELLS + 64);
  localparam int IDX_W       = LN_W + 8;
  localparam int CELL_W      = 16;
  localparam int QCNT_W      = $clog2(QW);

  typedef logic [QW-1:0]    lines_t;
  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [1:0]       reg_idx_t;

  localparam lines_t LINES_RST   = lines_t'(STORE_CELLS / 80);
  localparam idx_t   STORE_LIMIT = idx_t'(STORE_CELLS);

  // register map
  localparam reg_idx_t REG_WIDTH  = 2'd0;
  localparam reg_idx_t REG_HEIGHT = 2'd1;
  localparam reg_idx_t REG_ATTR   = 2'd2;

  localparam logic [7:0] RST_WIDTH  = 8'd80;
  localparam logic [6:0] RST_HEIGHT = 7'd25;
  localparam logic [7:0] RST_ATTR   = 8'd7;

  // opcodes
  localparam logic OP_PUT  = 1'b0;
  localparam logic OP_READ = 1'b1;

  // control characters
  localparam logic [7:0] CH_NEWLINE   = 8'd10;
  localparam logic [7:0] CH_RETURN    = 8'd13;
  localparam logic [7:0] CH_BACKSPACE = 8'd8;
  localparam logic [7:0] CH_SPACE     = 8'd32;

endpackage

### hw/rtl/tcse_ram.sv
// ----------------------------------------------------------------------------
// tcse_ram
// simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module tcse_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/tcse_lines_div.sv
// ----------------------------------------------------------------------------
// tcse_lines_div
// restoring divider, store lines = store cells / line width, one bit a cycle
// ----------------------------------------------------------------------------
module tcse_lines_div import tcse_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic [7:0] divisor,
  output logic       busy,
  output lines_t     quotient
);

  logic              run;
  logic [7:0]        dvsr;
  logic [7:0]        rem;
  lines_t            dvd;
  lines_t            quo;
  logic [QCNT_W-1:0] cnt;
  lines_t            lines;

  logic [8:0] trial;
  logic [8:0] diff;
  logic       ge;
  logic [7:0] rem_next;
  lines_t     quo_next;

  always_comb begin
    trial    = {rem, dvd[QW-1]};
    ge       = trial >= {1'b0, dvsr};
    diff     = trial - {1'b0, dvsr};
    rem_next = ge ? diff[7:0] : trial[7:0];
    quo_next = {quo[QW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run   <= 1'b0;
      lines <= LINES_RST;
    end else if (start) begin
      run  <= 1'b1;
      dvsr <= divisor;
      rem  <= '0;
      dvd  <= lines_t'(STORE_CELLS);
      cnt  <= QCNT_W'(QW - 1);
    end else if (run) begin
      rem <= rem_next;
      dvd <= dvd << 1;
      quo <= quo_next;
      cnt <= cnt - 1'b1;
      if (cnt == '0) begin
        run   <= 1'b0;
        lines <= quo_next;
      end
    end
  end

  assign busy     = run;
  assign quotient = lines;

endmodule

### hw/rtl/text_console_scroll_engine_top.sv
// ----------------------------------------------------------------------------
// text_console_scroll_engine_top
// text console: prints characters into a circular cell store and scrolls
// ----------------------------------------------------------------------------
// a scroll fills a fresh line with blanks and, when the store bottom is
//   passed, first copies the retained lines to the store top; a character
//   that fills its line wraps into a line feed
// throughput: one store access per cycle on the single cell ram sets the pace
// reset: synchronous; a clearing pass zeroes the store with busy high; a width
//   write keeps busy high while the store line count is recomputed
// the receiver cannot stall: done marks each result for exactly one cycle
module text_console_scroll_engine_top import tcse_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // command side
  input  logic        start,
  output logic        busy,
  input  logic        opcode,
  input  logic [7:0]  character,
  input  logic        last_char,
  input  logic [13:0] read_address,
  // result side
  output logic        done,
  output logic [15:0] cursor_offset,
  output logic [15:0] display_start,
  output logic [15:0] read_data
);

  // one-hot sequencer states
  typedef enum logic [12:0] {
    S_CLEAR = 13'b0000000000001, // clearing pass after reset
    S_IDLE  = 13'b0000000000010,
    S_RDW   = 13'b0000000000100, // cell read data arrives
    S_LB    = 13'b0000000001000, // line base multiply
    S_PUT   = 13'b0000000010000, // character write
    S_LF    = 13'b0000000100000, // line feed decision
    S_CPB   = 13'b0000001000000, // copy source base multiply
    S_CPN   = 13'b0000010000000, // copy length multiply
    S_CP    = 13'b0000100000000, // copy sweep
    S_FLM   = 13'b0001000000000, // new line base multiply
    S_FL    = 13'b0010000000000, // blank fill sweep
    S_SR    = 13'b0100000000000, // start register multiply
    S_FIN   = 13'b1000000000000  // cursor update, result
  } state_t;

  state_t state;

  // configuration registers
  logic [7:0] screen_width;
  logic [6:0] screen_height;
  logic [7:0] text_attribute;
  logic       cfg_wr;
  reg_idx_t   cfg_idx;

  // console state
  logic [7:0]      col;
  logic [6:0]      row;
  logic [LN_W-1:0] top;
  logic [15:0]     cursor_register;
  logic [15:0]     start_register;
  lines_t          store_lines;
  logic            div_busy;
  logic            div_start;
  logic [7:0]      div_dvsr;

  // sequencer working registers
  idx_t            lbase;
  idx_t            cbase;
  idx_t            ncount;
  idx_t            k;
  logic            pend;
  logic            pend_zero;
  idx_t            pend_addr;
  logic [AW-1:0]   clr;
  logic [7:0]      ch_q;
  logic            last_q;
  logic            lb_put;
  logic            rzero;
  logic [15:0]     read_data_q;

  // derived values
  logic [7:0]      eff_width;
  logic [6:0]      h0;
  logic [6:0]      eff_height;
  logic            accept;
  logic [LN_W-1:0] mul_a;
  idx_t            mul_p;
  logic [6:0]      row_c;
  logic [7:0]      row_inc;
  logic            no_scroll;
  logic [LN_W-1:0] top_inc;
  logic            copy_need;
  logic [8:0]      col_inc;
  idx_t            cp_ridx;
  logic            rd_issue;
  idx_t            ridx_in;

  // ram ports
  logic               w_req;
  idx_t               w_idx;
  logic [CELL_W-1:0]  w_data;
  logic               ram_we;
  logic [AW-1:0]      ram_raddr;
  logic [CELL_W-1:0]  ram_rdata;

  // --------------------------------------------------------------------------
  // configuration port
  // --------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width   <= RST_WIDTH;
      screen_height  <= RST_HEIGHT;
      text_attribute <= RST_ATTR;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_WIDTH:  screen_width   <= pwdata[7:0];
        REG_HEIGHT: screen_height  <= pwdata[6:0];
        REG_ATTR:   text_attribute <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_WIDTH:  prdata = {24'b0, screen_width};
      REG_HEIGHT: prdata = {25'b0, screen_height};
      REG_ATTR:   prdata = {24'b0, text_attribute};
      default:    prdata = '0;
    endcase
  end

  // a width write recomputes how many whole lines fit in the store
  assign div_start = cfg_wr && (cfg_idx == REG_WIDTH);
  assign div_dvsr  = (pwdata[7:0] == 8'd0) ? 8'd1 : pwdata[7:0];

  tcse_lines_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .divisor  (div_dvsr),
    .busy     (div_busy),
    .quotient (store_lines)
  );

  // width zero acts as one; height is clamped to one .. store lines
  assign eff_width = (screen_width == 8'd0) ? 8'd1 : screen_width;
  assign h0        = (screen_height == 7'd0) ? 7'd1 : screen_height;
  assign eff_height = (QW'(h0) > store_lines) ? store_lines[6:0] : h0;

  // --------------------------------------------------------------------------
  // shared multiplier: every product in the design is something times width
  // --------------------------------------------------------------------------
  always_comb begin
    if (state == S_CPB || state == S_SR) begin
      mul_a = top;
    end else if (state == S_CPN) begin
      mul_a = LN_W'(eff_height - 7'd1);
    end else begin
      mul_a = top + LN_W'(row);
    end
  end

  assign mul_p = idx_t'(mul_a) * idx_t'(eff_width);

  // line feed decision terms
  assign row_c     = (row >= eff_height) ? (eff_height - 7'd1) : row;
  assign row_inc   = {1'b0, row_c} + 8'd1;
  assign no_scroll = row_inc < {1'b0, eff_height};
  assign top_inc   = top + 1'b1;
  assign copy_need = ({1'b0, top_inc} + (LN_W+1)'(eff_height - 7'd1))
                     >= (LN_W+1)'(store_lines);

  assign col_inc = {1'b0, col} + 9'd1;

  // copy sweep writes each cell in the cycle after its read side issues it
  assign cp_ridx  = cbase + k;
  assign rd_issue = k < ncount;
  assign ridx_in  = idx_t'(read_address);

  assign busy   = (state != S_IDLE) || div_busy;
  assign accept = start && !busy;

  // --------------------------------------------------------------------------
  // cell ram access
  // --------------------------------------------------------------------------
  always_comb begin
    w_req  = 1'b0;
    w_idx  = '0;
    w_data = '0;
    unique case (state)
      S_CLEAR: begin
        w_req = 1'b1;
        w_idx = idx_t'(clr);
      end
      S_PUT: begin
        w_req  = 1'b1;
        w_idx  = lbase + idx_t'(col);
        w_data = {text_attribute, ch_q};
      end
      S_CP: begin
        w_req  = pend;
        w_idx  = pend_addr;
        w_data = pend_zero ? '0 : ram_rdata;
      end
      S_FL: begin
        w_req  = 1'b1;
        w_idx  = lbase + k;
        w_data = {text_attribute, CH_SPACE};
      end
      default: ;
    endcase
  end

  // cells past the end of the store are never written and read as zero
  assign ram_we    = w_req && (w_idx < STORE_LIMIT);
  assign ram_raddr = (state == S_CP) ? cp_ridx[AW-1:0] : ridx_in[AW-1:0];

  tcse_ram #(
    .WIDTH (CELL_W),
    .DEPTH (STORE_CELLS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (w_idx[AW-1:0]),
    .wdata (w_data),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // --------------------------------------------------------------------------
  // sequencer
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_CLEAR;
      clr             <= '0;
      col             <= '0;
      row             <= '0;
      top             <= '0;
      cursor_register <= '0;
      start_register  <= '0;
      pend            <= 1'b0;
      done            <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          clr <= clr + 1'b1;
          if (clr == AW'(STORE_CELLS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            ch_q   <= character;
            last_q <= last_char;
            if (opcode == OP_READ) begin
              rzero <= !(ridx_in < STORE_LIMIT);
              state <= S_RDW;
            end else begin
              priority if (character == CH_NEWLINE) begin
                state <= S_LF;
              end else if (character == CH_RETURN) begin
                col    <= '0;
                lb_put <= 1'b0;
                state  <= S_LB;
              end else if (character == CH_BACKSPACE) begin
                if (col != 8'd0) begin
                  col <= col - 8'd1;
                end
                lb_put <= 1'b0;
                state  <= S_LB;
              end else begin
                lb_put <= 1'b1;
                state  <= S_LB;
              end
            end
          end
        end
        S_RDW: begin
          read_data_q <= rzero ? '0 : ram_rdata;
          done        <= 1'b1;
          state       <= S_IDLE;
        end
        S_LB: begin
          lbase <= mul_p;
          state <= lb_put ? S_PUT : S_FIN;
        end
        S_PUT: begin
          // full line wraps into a line feed
          if (col_inc >= {1'b0, eff_width}) begin
            col   <= '0;
            state <= S_LF;
          end else begin
            col   <= col_inc[7:0];
            state <= S_FIN;
          end
        end
        S_LF: begin
          col <= '0;
          if (no_scroll) begin
            row    <= row_inc[6:0];
            lb_put <= 1'b0;
            state  <= S_LB;
          end else begin
            row <= eff_height - 7'd1;
            top <= top_inc;
            state <= copy_need ? S_CPB : S_FLM;
          end
        end
        S_CPB: begin
          cbase <= mul_p;
          state <= S_CPN;
        end
        S_CPN: begin
          ncount <= mul_p;
          k      <= '0;
          pend   <= 1'b0;
          state  <= S_CP;
        end
        S_CP: begin
          if (rd_issue) begin
            k         <= k + 1'b1;
            pend      <= 1'b1;
            pend_addr <= k;
            pend_zero <= !(cp_ridx < STORE_LIMIT);
          end else begin
            pend <= 1'b0;
          end
          // retained lines now sit at the top of the store
          if (!rd_issue && !pend) begin
            top   <= '0;
            state <= S_FLM;
          end
        end
        S_FLM: begin
          lbase <= mul_p;
          k     <= '0;
          state <= S_FL;
        end
        S_FL: begin
          k <= k + 1'b1;
          if (k == idx_t'(eff_width) - 1'b1) begin
            state <= S_SR;
          end
        end
        S_SR: begin
          start_register <= mul_p[15:0];
          state          <= S_FIN;
        end
        S_FIN: begin
          if (last_q) begin
            cursor_register <= 16'(lbase + idx_t'(col));
          end
          read_data_q <= '0;
          done        <= 1'b1;
          state       <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign cursor_offset = cursor_register;
  assign display_start = start_register;
  assign read_data     = read_data_q;

`ifndef SYNTHESIS
  // every finished command produces exactly one result transfer
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN || state == S_RDW) |=> done)
    else $error("result strobe missing");

  a_single_strobe: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe longer than one cycle");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy)
    else $error("accepted command left the block idle");

  // the copy never overwrites a cell it has yet to read
  a_copy_order: assert property (@(posedge clk) disable iff (rst)
    (state == S_CP && pend && rd_issue) |-> (pend_addr < cp_ridx))
    else $error("copy write overtakes its reads");

  a_height_nonzero: assert property (@(posedge clk) disable iff (rst)
    eff_height != 7'd0)
    else $error("effective height is zero");
`endif

endmodule
